FILE: rtl/bic_pkg.sv
package bic_pkg;

  localparam int MAX_VARS = 32;
  localparam int VAR_W    = $clog2(MAX_VARS);
  localparam int NV_W     = 6;
  localparam int WORD_W   = 64;
  localparam int WIDX_W   = 26;
  localparam int TAG_W    = 8;
  localparam int VIDX_W   = 5;
  localparam int ACC_W    = 34;
  localparam int MAG_W    = 33;
  localparam int POP_W    = 7;
  localparam int DELTA_W  = 8;
  localparam int SUM_W    = ACC_W + 1;
  localparam int LO_VARS  = 6;

  localparam int Q_DEPTH  = 4;
  localparam int QA_W     = $clog2(Q_DEPTH);

  localparam logic signed [SUM_W-1:0] CORR_LIMIT = 35'sd4294967296;

  localparam logic [LO_VARS-1:0][WORD_W-1:0] VAR_PATTERNS = {
    64'hFFFFFFFF00000000,
    64'hFFFF0000FFFF0000,
    64'hFF00FF00FF00FF00,
    64'hF0F0F0F0F0F0F0F0,
    64'hCCCCCCCCCCCCCCCC,
    64'hAAAAAAAAAAAAAAAA
  };

  typedef enum logic {
    ST_RUN,
    ST_EMIT
  } bk_state_t;

  // one classified word: per-variable deltas for the in-word variables
  typedef struct packed {
    logic [LO_VARS-1:0][DELTA_W-1:0] lo_delta;
    logic [POP_W-1:0]                pop;
    logic [WIDX_W-1:0]               widx;
    logic [TAG_W-1:0]                tag;
    logic                            last;
    logic [NV_W-1:0]                 nvars;
  } q_entry_t;

  // per-byte counts, then a balanced adder tree
  function automatic logic [POP_W-1:0] popcnt64(input logic [WORD_W-1:0] v);
    logic [3:0] b [8];
    logic [4:0] q [4];
    logic [5:0] h [2];
    for (int j = 0; j < 8; j++) begin
      b[j] = '0;
      for (int k = 0; k < 8; k++) begin
        b[j] = b[j] + 4'(v[8*j+k]);
      end
    end
    for (int j = 0; j < 4; j++) begin
      q[j] = {1'b0, b[2*j]} + {1'b0, b[2*j+1]};
    end
    for (int j = 0; j < 2; j++) begin
      h[j] = {1'b0, q[2*j]} + {1'b0, q[2*j+1]};
    end
    return {1'b0, h[0]} + {1'b0, h[1]};
  endfunction

endpackage

FILE: rtl/bic_front.sv
module bic_front
  import bic_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [NV_W-1:0]   cfg_wdata,
  input  logic [WORD_W-1:0] table_word,
  input  logic [WIDX_W-1:0] word_index,
  input  logic [TAG_W-1:0]  function_index,
  input  logic              final_word,
  output q_entry_t          entry
);

  logic [NV_W-1:0] var_count_r;
  logic [NV_W-1:0] var_count_nxt;
  logic [NV_W-1:0] nvars;
  logic [POP_W-1:0] pop;
  logic [POP_W-1:0] ones [LO_VARS];

  always_comb begin
    var_count_nxt = cfg_we ? cfg_wdata : var_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r <= NV_W'(MAX_VARS);
    end else begin
      var_count_r <= var_count_nxt;
    end
  end

  // zero means one variable, anything above the lane count saturates
  always_comb begin
    nvars = var_count_r;
    if (nvars == '0) begin
      nvars = NV_W'(1);
    end
    if (nvars > NV_W'(MAX_VARS)) begin
      nvars = NV_W'(MAX_VARS);
    end
  end

  always_comb begin
    pop = popcnt64(table_word);
    for (int i = 0; i < LO_VARS; i++) begin
      ones[i] = popcnt64(table_word & VAR_PATTERNS[i]);
    end
  end

  always_comb begin
    entry.pop   = pop;
    entry.widx  = word_index;
    entry.tag   = function_index;
    entry.last  = final_word;
    entry.nvars = nvars;
    // ones minus zeros = 2*ones - pop
    for (int i = 0; i < LO_VARS; i++) begin
      entry.lo_delta[i] = {ones[i], 1'b0} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/bic_queue.sv
module bic_queue
  import bic_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t din,
  input  logic     pop,
  output q_entry_t dout,
  output logic     full,
  output logic     empty
);

  q_entry_t        mem_r [Q_DEPTH];
  logic [QA_W-1:0] wr_ptr_r;
  logic [QA_W-1:0] wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r;
  logic [QA_W-1:0] rd_ptr_nxt;
  logic [QA_W:0]   count_r;
  logic [QA_W:0]   count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == (QA_W+1)'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QA_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QA_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QA_W+1)'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - (QA_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: rtl/bic_back.sv
module bic_back
  import bic_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  q_entry_t                head,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [TAG_W-1:0]        out_func_tag,
  output logic [VIDX_W-1:0]       out_var_index,
  output logic signed [ACC_W-1:0] out_raw_corr,
  output logic [MAG_W-1:0]        out_corr_mag,
  output logic                    out_run_end
);

  bk_state_t state_r;
  bk_state_t state_nxt;

  logic signed [ACC_W-1:0]   corr_r   [MAX_VARS];
  logic signed [ACC_W-1:0]   corr_nxt [MAX_VARS];
  logic signed [DELTA_W-1:0] lane_delta [MAX_VARS];

  logic [VAR_W-1:0]  pos_r;
  logic [VAR_W-1:0]  pos_nxt;
  logic [NV_W-1:0]   n_r;
  logic [NV_W-1:0]   n_nxt;
  logic [TAG_W-1:0]  tag_r;
  logic [TAG_W-1:0]  tag_nxt;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [TAG_W-1:0]        out_tag_r;
  logic [VIDX_W-1:0]       out_vidx_r;
  logic signed [ACC_W-1:0] out_raw_r;
  logic [MAG_W-1:0]        out_mag_r;
  logic                    out_end_r;

  logic                    pop_en;
  logic                    emit_en;
  logic                    out_free;
  logic                    last_pos;
  logic signed [ACC_W-1:0] sel_raw;
  logic [ACC_W-1:0]        sel_abs;
  logic signed [DELTA_W-1:0] pop_s;

  assign out_free = !out_valid_r || !out_stall;
  assign last_pos = (NV_W'(pos_r) == n_r - NV_W'(1));
  assign pop_s    = $signed({1'b0, head.pop});

  // per-variable delta: in-word variables from the front, the rest by word index bit
  for (genvar i = 0; i < MAX_VARS; i++) begin : g_lane
    if (i < LO_VARS) begin : g_lo
      assign lane_delta[i] = $signed(head.lo_delta[i]);
    end else begin : g_hi
      assign lane_delta[i] = head.widx[i-LO_VARS] ? pop_s : -pop_s;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (pop_en && head.last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_en && last_pos) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    pop_en  = 1'b0;
    emit_en = 1'b0;
    unique case (state_r)
      ST_RUN:  pop_en  = !q_empty;
      ST_EMIT: emit_en = out_free;
      default: begin
        pop_en  = 1'b0;
        emit_en = 1'b0;
      end
    endcase
  end

  assign q_pop = pop_en;

  // saturating counter update, all lanes in parallel
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < MAX_VARS; i++) begin
      corr_nxt[i] = corr_r[i];
      if (pop_en && (NV_W'(i) < head.nvars)) begin
        sum = SUM_W'(corr_r[i]) + SUM_W'(lane_delta[i]);
        if (sum > CORR_LIMIT) begin
          sum = CORR_LIMIT;
        end else if (sum < -CORR_LIMIT) begin
          sum = -CORR_LIMIT;
        end
        corr_nxt[i] = sum[ACC_W-1:0];
      end
      if (emit_en && last_pos) begin
        corr_nxt[i] = '0;
      end
    end
  end

  always_comb begin
    sel_raw = corr_r[pos_r];
    sel_abs = sel_raw[ACC_W-1] ? ACC_W'(-sel_raw) : ACC_W'(sel_raw);
  end

  always_comb begin
    pos_nxt = pos_r;
    n_nxt   = n_r;
    tag_nxt = tag_r;
    if (pop_en && head.last) begin
      pos_nxt = '0;
      n_nxt   = head.nvars;
      tag_nxt = head.tag;
    end else if (emit_en) begin
      pos_nxt = last_pos ? '0 : pos_r + VAR_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_en) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_VARS; i++) begin
        corr_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < MAX_VARS; i++) begin
        corr_r[i] <= corr_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    tag_r <= tag_nxt;
    if (emit_en) begin
      out_tag_r  <= tag_r;
      out_vidx_r <= VIDX_W'(pos_r);
      out_raw_r  <= sel_raw;
      out_mag_r  <= sel_abs[MAG_W-1:0];
      out_end_r  <= last_pos;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_func_tag  = out_tag_r;
  assign out_var_index = out_vidx_r;
  assign out_raw_corr  = out_raw_r;
  assign out_corr_mag  = out_mag_r;
  assign out_run_end   = out_end_r;

endmodule

FILE: rtl/boolean_input_correlation.sv
// first-order walsh spectrum of a boolean function from a stream of truth table words
//
// input channel: in_valid / in_stall with one 64-bit table word, its word index, the
// function tag and a final flag. a request is taken whenever the 4-entry word queue
// has room; words stream in at one per clock while it has room.
// config: cfg_we / cfg_wdata writes the variable count (0 acts as 1, above 32 as 32).
// write it only while the block is idle.
// each word is popcounted on entry and queued; the back end applies it to the signed
// counters of all active variables at once, so non-final words sustain one per clock
// outside emission. result channel: out_valid / out_stall, one request per variable
// after a final word, which passes the word queue and the back end state register
// before the first result is registered; then one per cycle while the receiver does
// not stall; the counter array is read one variable per cycle. while emitting, the
// back end pops no words; up to 4 further words queue meanwhile. counters clear
// after the last variable (out_run_end). a stalled result holds, and emission waits.
// reset (rst_n low, synchronous) clears the counters, empties the queue, drops
// out_valid and sets the variable count to 32.
module boolean_input_correlation
  import bic_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [NV_W-1:0]         cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [WORD_W-1:0]       in_table_word,
  input  logic [WIDX_W-1:0]       in_word_index,
  input  logic [TAG_W-1:0]        in_function_index,
  input  logic                    in_final_word,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [TAG_W-1:0]        out_func_tag,
  output logic [VIDX_W-1:0]       out_var_index,
  output logic signed [ACC_W-1:0] out_raw_corr,
  output logic [MAG_W-1:0]        out_corr_mag,
  output logic                    out_run_end
);

  q_entry_t front_entry;
  q_entry_t head;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;

  assign in_stall = q_full;

  bic_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .table_word     (in_table_word),
    .word_index     (in_word_index),
    .function_index (in_function_index),
    .final_word     (in_final_word),
    .entry          (front_entry)
  );

  bic_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_valid),
    .din   (front_entry),
    .pop   (q_pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  bic_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_func_tag  (out_func_tag),
    .out_var_index (out_var_index),
    .out_raw_corr  (out_raw_corr),
    .out_corr_mag  (out_corr_mag),
    .out_run_end   (out_run_end)
  );

endmodule
